// ===== rtl/vra_pkg.sv =====
// Package for the value rank assigner.
// Holds the field widths and default sizing shared by the store and the top level.
// No dependencies.
`default_nettype none

package vra_pkg;

  localparam int VALUE_W       = 32;
  localparam int POS_W         = 6;
  localparam int RANK_W        = 6;
  localparam int OUT_TDATA_W   = 16;
  localparam int MAX_ITEMS_DEF = 64;

endpackage

`default_nettype wire

// ===== rtl/value_rank_assigner.sv =====
// Value rank assigner: ranks a list of signed values, smallest first.
// Depends on vra_pkg and vra_store.
//
// Usage: the slave channel takes one signed 32-bit value per transaction in
// s_tdata, with s_tlast marking the final value of a list. Up to MAX_ITEMS
// values are kept; further values are dropped and the overflow flag is set.
// Loading takes one value per cycle.
// After the last transaction the block ranks each stored element in input
// order. For every element it reads the element once and then scans the
// whole store through the second read port of the memory, one comparison a
// cycle, and then hands the rank to the output register.
// Each result leaves through an output register on the master channel:
// position and rank in m_tdata, m_tlast on the last element, m_tuser as the
// overflow flag. Equal values give the earlier element the higher rank.
// s_tready is low while a list is being ranked. When the receiver stalls,
// the result is held and ranking pauses until it is taken; a new list may
// be loaded while the final result still waits.
// Reset empties the list and clears m_tvalid, not the output data; no clearing pass.
`default_nettype none

module value_rank_assigner #(
  parameter int MAX_ITEMS = vra_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [vra_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
  input  wire logic                            s_tlast,   // last
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  output      logic [vra_pkg::OUT_TDATA_W-1:0] m_tdata,   // [5:0] position, [11:6] rank
  output      logic                            m_tlast,   // final_res
  output      logic                            m_tuser    // overflow
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                             state;
  logic [CNT_W-1:0]                   count;
  logic                               ovf;
  logic [IDX_W-1:0]                   idx_i;
  logic [IDX_W-1:0]                   idx_j;
  logic [CNT_W-1:0]                   rank;
  logic [CNT_W-1:0]                   rank_next;
  logic                               in_fire;
  logic                               has_room;
  logic                               hit;
  logic                               j_last;
  logic                               i_last;
  logic                               emit_go;
  logic [IDX_W-1:0]                   rd_addr_b;
  logic signed [vra_pkg::VALUE_W-1:0] elem_i;
  logic signed [vra_pkg::VALUE_W-1:0] elem_j;

  assign s_tready = (state == ST_LOAD);
  assign in_fire  = s_tvalid && s_tready;
  assign has_room = (count < CNT_W'(MAX_ITEMS));
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Port A holds the element being ranked; port B sweeps the store.
  assign rd_addr_b = (state == ST_SETUP) ? '0 : IDX_W'(idx_j + 1'b1);

  vra_store #(
    .DEPTH (MAX_ITEMS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_fire && has_room),
    .wr_addr   (count[IDX_W-1:0]),
    .wr_data   (s_tdata),
    .rd_addr_a (idx_i),
    .rd_data_a (elem_i),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (elem_j)
  );

  assign hit       = (elem_j < elem_i) || ((elem_j == elem_i) && (idx_j > idx_i));
  assign rank_next = rank + CNT_W'(hit);
  assign j_last    = (CNT_W'(idx_j) + CNT_W'(1) == count);
  assign i_last    = (CNT_W'(idx_i) + CNT_W'(1) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      idx_i    <= '0;
      idx_j    <= '0;
      rank     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              idx_i <= '0;
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          idx_j <= '0;
          rank  <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          rank <= rank_next;
          if (j_last) begin
            state <= ST_EMIT;
          end else begin
            idx_j <= idx_j + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_tdata  <= {(vra_pkg::OUT_TDATA_W - vra_pkg::POS_W - vra_pkg::RANK_W)'(0),
                         vra_pkg::RANK_W'(rank), vra_pkg::POS_W'(idx_i)};
            m_tlast  <= i_last;
            m_tuser  <= ovf;
            if (i_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end else begin
              idx_i <= idx_i + 1'b1;
              state <= ST_SETUP;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count exceeds capacity");

  a_scan_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CNT_W'(idx_j) < count) && (CNT_W'(idx_i) < count))
    else $error("scan index outside the stored list");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rank < count))
    else $error("rank not below element count");

  a_no_load_while_ranking: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (state == ST_SCAN) || (state == ST_EMIT))
    else $error("scan left without reaching emit");

endmodule

`default_nettype wire

// ===== rtl/vra_store.sv =====
// Element store of the value rank assigner: one write port and two read ports.
// Both reads are registered, so data appears in the cycle after the address.
// Depends on vra_pkg for the element width.
`default_nettype none

module vra_store #(
  parameter int DEPTH = vra_pkg::MAX_ITEMS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [IDX_W-1:0]                  wr_addr,
  input  wire logic signed [vra_pkg::VALUE_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]                  rd_addr_a,
  output      logic signed [vra_pkg::VALUE_W-1:0] rd_data_a,
  input  wire logic [IDX_W-1:0]                  rd_addr_b,
  output      logic signed [vra_pkg::VALUE_W-1:0] rd_data_b
);

  logic signed [vra_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== test/value_rank_checker.sv =====
`timescale 1ns / 100ps
// Checker for the value rank assigner: watches both stream channels, predicts ranks.
// Depends on vra_pkg; reports a failure count and the number of results still due.
module value_rank_checker #(
  parameter int MAX_ITEMS = vra_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [vra_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
  input  logic                            s_tlast,   // last
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [vra_pkg::OUT_TDATA_W-1:0] m_tdata,   // [5:0] position, [11:6] rank
  input  logic                            m_tlast,   // final_res
  input  logic                            m_tuser,   // overflow
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [vra_pkg::POS_W-1:0]  position;
    logic [vra_pkg::RANK_W-1:0] rank;
    logic                       final_res;
    logic                       overflow;
  } rank_result_t;

  logic signed [vra_pkg::VALUE_W-1:0] list_values [MAX_ITEMS];
  int                                 list_len;
  bit                                 list_dropped;
  rank_result_t                       ranks_due [$];

  // Smaller values count, and so do equal values that arrived later.
  function automatic logic [vra_pkg::RANK_W-1:0] rank_of_entry(input int idx);
    int below;
    below = 0;
    for (int j = 0; j < list_len; j++) begin
      if (list_values[j] < list_values[idx] ||
          (list_values[j] == list_values[idx] && j > idx))
        below++;
    end
    return below[vra_pkg::RANK_W-1:0];
  endfunction

  task automatic check_field(input string name, input int unsigned pos,
                             input logic [31:0] want_v, input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s of position %0d: expected %0d, actual %0d",
               $time, name, pos, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rank_result_t want;
    if (rst) begin
      list_len     = 0;
      list_dropped = 1'b0;
      errors       = 0;
      ranks_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (list_len < MAX_ITEMS) begin
          list_values[list_len] = s_tdata;
          list_len++;
        end else begin
          list_dropped = 1'b1;
        end
        // The last mark counts even when its own value was dropped.
        if (s_tlast) begin
          for (int i = 0; i < list_len; i++) begin
            want.position  = i[vra_pkg::POS_W-1:0];
            want.rank      = rank_of_entry(i);
            want.final_res = (i == list_len - 1);
            want.overflow  = list_dropped;
            ranks_due.push_back(want);
          end
          list_len     = 0;
          list_dropped = 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (ranks_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: actual tdata %h, tlast %b, tuser %b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = ranks_due.pop_front();
          check_field("position", want.position, want.position, m_tdata[5:0]);
          check_field("rank", want.position, want.rank, m_tdata[11:6]);
          check_field("padding", want.position, 0, m_tdata[15:12]);
          check_field("final_res", want.position, want.final_res, m_tlast);
          check_field("overflow", want.position, want.overflow, m_tuser);
        end
      end
    end
    pending = ranks_due.size();
  end

endmodule

// ===== test/value_rank_assigner_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the value rank assigner: clock, reset, stimulus and verdict.
// Depends on vra_pkg, value_rank_assigner and value_rank_checker.
module value_rank_assigner_tb;

  localparam logic [31:0] INT_MIN   = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
  localparam int          HOLD_LEN  = 400;
  // The tail only covers stragglers.
  localparam int          TAIL_LEN  = 300;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [vra_pkg::VALUE_W-1:0]     s_tdata  = '0;
  logic                            s_tlast  = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [vra_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;
  logic                            m_tuser;

  int errors;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_req  = 1'b0;

  value_rank_assigner dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  value_rank_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom();
    // A narrow pool around zero gives plenty of equal values.
    if (roll < 70) return 32'($urandom_range(0, 8)) - 32'd4;
    if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       return INT_MIN;
        1:       return INT_MAX;
        2:       return 32'd0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return (INT_MIN + 32'($urandom_range(0, 3))) ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
  endfunction

  task automatic offer(input logic [31:0] v, input logic l);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_fixed(input logic [31:0] vals [$]);
    foreach (vals[i]) offer(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) offer(pick_value(), i == len - 1);
  endtask

  task automatic send_lists_until(input int target);
    while (items_sent < target)
      send_list(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes and alternating bit patterns, a lone element, a run of equal
    // values, and a descending pair with the most negative value last.
    send_fixed({INT_MIN, INT_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1, INT_MIN, INT_MAX,
                32'h5555_5555, 32'hAAAA_AAAA});
    send_fixed({32'd0});
    send_fixed({32'd7, 32'd7, 32'd7, 32'd7});
    send_fixed({INT_MAX, INT_MIN});

    // A full store, then one that overflows with its last value dropped.
    send_list(64);
    send_list(66);
    send_lists_until(190);

    idle_pct = 72;
    send_lists_until(250);

    idle_pct  = 0;
    stall_pct = 72;
    send_list(65);
    send_lists_until(350);

    idle_pct  = 33;
    stall_pct = 33;
    send_lists_until(400);

    // The receiver holds off while lists keep coming, so the input backs up.
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    send_lists_until(430);
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("value_rank_assigner: match");
    else
      $display("value_rank_assigner: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("value_rank_assigner: mismatch");
    $finish;
  end

endmodule
